FILE: design/otp_pkg.sv
// ----------------------------------------------------------------------------
// otp_pkg: shared types and codes of the one-shot timer pool
// Command and status codes, beat structs and the slot memory word.
// ----------------------------------------------------------------------------
package otp_pkg;

    // default pool size
    localparam int NUM_SLOTS_DEFAULT = 16;

    // field widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;
    localparam int WORD_W   = 32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUIET    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd5;

    // input beat
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] handler_id;
        logic [WORD_W-1:0] handler_arg;
        logic [WORD_W-1:0] timeout_ticks;
        logic [IDX_W-1:0]  slot_index;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    result_slot;
        logic [WORD_W-1:0]   fired_handler;
        logic [WORD_W-1:0]   fired_arg;
        logic [WORD_W-1:0]   tick_now;
    } out_beat_t;

    // one slot of the timer memory
    typedef struct packed {
        logic [WORD_W-1:0] handler;
        logic [WORD_W-1:0] arg;
        logic [WORD_W-1:0] deadline;
    } slot_entry_t;

endpackage

FILE: design/one_shot_timer_pool.sv
// ----------------------------------------------------------------------------
// one_shot_timer_pool: pool of one-shot timers on a 32-bit tick counter
// Create, delete and tick commands, one result beat per command beat.
// ----------------------------------------------------------------------------
// Create and delete are answered from the idle state: the lowest free slot
// comes from the used-bit flops and, for a create, the handler, argument and
// deadline are written to the slot memory. A tick runs a scan that ends at
// the slot that fires, or at the last slot when nothing fires: the slot
// memory has one read port, so the scan looks at one slot per cycle in slot
// order and stops at the first used slot whose deadline is at or below the
// new counter. A new command beat is taken while idle as soon as the result
// register is empty or being drained. No clearing pass is needed after reset.
module one_shot_timer_pool #(
    parameter int NUM_SLOTS = otp_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  otp_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output otp_pkg::out_beat_t m_data
);
    import otp_pkg::*;

    localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                 state_reg, state_next;
    logic [WORD_W-1:0]    tick_reg, tick_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [SlotW-1:0]     scan_idx_reg, scan_idx_next;
    logic                 m_valid_reg, m_valid_next;
    out_beat_t            out_reg, out_next;

    logic                 accept;
    logic                 free_found;
    logic [SlotW-1:0]     free_idx;
    logic                 create_ok;
    logic                 hit;
    logic                 scan_last;
    logic                 mem_wr_en;
    slot_entry_t          mem_wr_data;
    logic [SlotW-1:0]     mem_rd_addr;
    slot_entry_t          mem_rd_data;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SlotW'(i);
            end
        end
    end

    assign create_ok = (s_data.handler_id != '0) && (s_data.timeout_ticks != '0);

    // scan compare on the slot read last cycle
    assign hit       = used_reg[scan_idx_reg] && (tick_reg >= mem_rd_data.deadline);
    assign scan_last = (scan_idx_reg == SlotW'(NUM_SLOTS - 1));

    // slot memory write data
    assign mem_wr_data.handler  = s_data.handler_id;
    assign mem_wr_data.arg      = s_data.handler_arg;
    assign mem_wr_data.deadline = tick_reg + s_data.timeout_ticks;

    // command sequencer
    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        used_next     = used_reg;
        scan_idx_next = scan_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        mem_wr_en     = 1'b0;
        mem_rd_addr   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_next               = '0;
                    out_next.status        = ST_REJECTED;
                    out_next.tick_now      = tick_reg;
                    m_valid_next           = 1'b1;
                    case (s_data.cmd)
                        CMD_CREATE: begin
                            if (!create_ok) begin
                                out_next.status = ST_REJECTED;
                            end else if (!free_found) begin
                                out_next.status = ST_FULL;
                            end else begin
                                out_next.status      = ST_CREATED;
                                out_next.result_slot = IDX_W'(free_idx);
                                used_next[free_idx]  = 1'b1;
                                mem_wr_en            = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            out_next.status = ST_DELETED;
                            if ({1'b0, s_data.slot_index} < (IDX_W + 1)'(NUM_SLOTS)) begin
                                used_next[s_data.slot_index[SlotW-1:0]] = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            // result comes from the scan
                            m_valid_next  = 1'b0;
                            tick_next     = tick_reg + 1'b1;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                            out_next.status = ST_REJECTED;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                mem_rd_addr = scan_idx_reg + 1'b1;
                if (hit || scan_last) begin
                    out_next          = '0;
                    out_next.tick_now = tick_reg;
                    m_valid_next      = 1'b1;
                    state_next        = ST_IDLE;
                    if (hit) begin
                        out_next.status         = ST_FIRED;
                        out_next.result_slot    = IDX_W'(scan_idx_reg);
                        out_next.fired_handler  = mem_rd_data.handler;
                        out_next.fired_arg      = mem_rd_data.arg;
                        used_next[scan_idx_reg] = 1'b0;
                    end else begin
                        out_next.status = ST_QUIET;
                    end
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            used_reg     <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            used_reg     <= used_next;
            scan_idx_reg <= scan_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // slot memory
    otp_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (free_idx),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // the scan never runs while a result is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !m_valid_reg)
        else $error("scan running with result pending");

    // a tick beat advances the counter by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_TICK) |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick counter did not advance");

    // a successful create takes exactly one more slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_CREATE && create_ok && free_found)
        |=> ($countones(used_reg) == $past($countones(used_reg)) + 1))
        else $error("create did not take one slot");

    // a fired timer always carries a nonzero handler
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status == ST_FIRED) |-> (out_reg.fired_handler != '0))
        else $error("fired timer with empty handler");

    // a firing scan frees one slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && hit)
        |=> ($countones(used_reg) + 1 == $past($countones(used_reg))))
        else $error("fired slot not freed");

endmodule

FILE: design/otp_slot_store.sv
// ----------------------------------------------------------------------------
// otp_slot_store: timer slot memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module otp_slot_store #(
    parameter int NUM_SLOTS = otp_pkg::NUM_SLOTS_DEFAULT,
    localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [SlotW-1:0]     wr_addr,
    input  otp_pkg::slot_entry_t wr_data,
    input  logic [SlotW-1:0]     rd_addr,
    output otp_pkg::slot_entry_t rd_data
);
    import otp_pkg::*;

    slot_entry_t mem [NUM_SLOTS];
    slot_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
